// File: design/tiled_texture_block_decoder_top_macros.svh
// ============================================================================
// Assertion macros for tiled_texture_block_decoder_top
// Shared forms for the concurrent checks on the top-level ports.
// ============================================================================
`ifndef TILED_TEXTURE_BLOCK_DECODER_TOP_MACROS_SVH
`define TILED_TEXTURE_BLOCK_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset
`define TTBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ttbd check failed");

// Next-cycle implication, disabled in reset
`define TTBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttbd check failed");

`endif

// File: design/ttbd_pkg.sv
// ============================================================================
// ttbd_pkg
// Types and constants shared by the tiled texture block decoder modules.
// ============================================================================
`default_nettype none

package ttbd_pkg;

    // Texture formats
    localparam logic FMT_RGB5A3 = 1'b0;
    localparam logic FMT_CMP    = 1'b1;

    // Configuration register indexes
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t REG_FORMAT = 2'd0;
    localparam cfg_index_t REG_WIDTH  = 2'd1;
    localparam cfg_index_t REG_HEIGHT = 2'd2;

    localparam int CFG_W   = 9;
    localparam int COL_W   = 8;
    localparam int COORD_W = 10;

    // One classified word on its way from front to back
    typedef struct packed {
        logic [63:0]        word;
        logic               fmt;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic               wrap;
    } work_entry_t;

    // Front to queue write side
    typedef struct packed {
        logic        push;
        work_entry_t entry;
    } queue_write_t;

endpackage

`default_nettype wire

// File: design/ttbd_front.sv
// ============================================================================
// ttbd_front
// Accepts input words, tracks the tile position and tags each word with its
// base coordinates and end-of-image flag before it enters the queue.
// ============================================================================
`default_nettype none

module ttbd_front #(
    parameter int MAX_DIM = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [63:0]                data_word,
    input  wire logic                       fmt,
    input  wire logic [ttbd_pkg::CFG_W-1:0] width_tiles,
    input  wire logic [ttbd_pkg::CFG_W-1:0] height_tiles,
    input  wire logic                       q_full,
    output ttbd_pkg::queue_write_t          q_wr
);
    import ttbd_pkg::*;

    localparam int TILE_CAP_I = ((MAX_DIM / 4) < 256) ? (MAX_DIM / 4) : 256;
    localparam logic [CFG_W-1:0] TILE_CAP = CFG_W'(TILE_CAP_I);

    logic [COL_W-1:0]   col_reg, col_next;
    logic [COORD_W-1:0] base_reg, base_next;
    logic [1:0]         sub_reg, sub_next;
    logic [1:0]         row_reg, row_next;

    logic               accept;
    logic [CFG_W-1:0]   w_eff, h_eff;
    logic [CFG_W-1:0]   step;
    logic [COORD_W:0]   drop;
    logic               do_adv;
    logic [CFG_W-1:0]   col_sum;
    logic [COORD_W:0]   base_sum;
    logic [COORD_W:0]   h_pix;
    logic               wrap;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // Clamp the image size to the supported range
    always_comb
    begin
        w_eff = width_tiles;
        if (width_tiles == '0)
            w_eff = CFG_W'(1);
        else if (width_tiles > TILE_CAP)
            w_eff = TILE_CAP;
        h_eff = height_tiles;
        if (height_tiles == '0)
            h_eff = CFG_W'(1);
        else if (height_tiles > TILE_CAP)
            h_eff = TILE_CAP;
    end

    // Advance the position and tag the word
    always_comb
    begin
        col_next  = col_reg;
        base_next = base_reg;
        sub_next  = sub_reg;
        row_next  = row_reg;
        wrap      = 1'b0;
        do_adv    = 1'b0;
        step      = CFG_W'(1);
        drop      = (COORD_W+1)'(4);

        q_wr.push       = accept;
        q_wr.entry.word = data_word;
        q_wr.entry.fmt  = fmt;
        q_wr.entry.wrap = 1'b0;

        if (fmt == FMT_CMP)
        begin
            q_wr.entry.x0 = {COORD_W'({1'b0, col_reg} + {{COL_W{1'b0}}, sub_reg[0]})} << 2;
            q_wr.entry.y0 = base_reg + {{(COORD_W-3){1'b0}}, sub_reg[1], 2'b00};
            step = CFG_W'(2);
            drop = (COORD_W+1)'(8);
            if (sub_reg == 2'd3)
            begin
                sub_next = 2'd0;
                do_adv   = 1'b1;
            end
            else
                sub_next = sub_reg + 2'd1;
        end
        else
        begin
            q_wr.entry.x0 = {{(COORD_W-COL_W){1'b0}}, col_reg} << 2;
            q_wr.entry.y0 = base_reg + {{(COORD_W-2){1'b0}}, row_reg};
            if (row_reg == 2'd3)
            begin
                row_next = 2'd0;
                do_adv   = 1'b1;
            end
            else
                row_next = row_reg + 2'd1;
        end

        col_sum  = {1'b0, col_reg} + step;
        base_sum = {1'b0, base_reg} + drop;
        h_pix    = {h_eff, 2'b00};
        if (do_adv)
        begin
            if (col_sum >= w_eff)
            begin
                col_next = '0;
                if (base_sum >= h_pix)
                begin
                    base_next = '0;
                    wrap      = 1'b1;
                end
                else
                    base_next = base_sum[COORD_W-1:0];
            end
            else
                col_next = col_sum[COL_W-1:0];
        end
        q_wr.entry.wrap = wrap;
    end

    // Update the position on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            base_reg <= '0;
            sub_reg  <= '0;
            row_reg  <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            base_reg <= base_next;
            sub_reg  <= sub_next;
            row_reg  <= row_next;
        end
    end

endmodule

`default_nettype wire

// File: design/ttbd_queue.sv
// ============================================================================
// ttbd_queue
// Two-entry queue that decouples the front end from the texel back end.
// ============================================================================
`default_nettype none

module ttbd_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ttbd_pkg::queue_write_t q_wr,
    output logic                       full,
    output logic                       not_empty,
    input  wire logic                  pop,
    output ttbd_pkg::work_entry_t      head
);
    import ttbd_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    work_entry_t        mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]     count_reg;
    logic               do_push, do_pop;

    assign full      = (count_reg == (PTR_W+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = q_wr.push && !full;
    assign do_pop    = pop && not_empty;

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= q_wr.entry;
    end

    // Track pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + (PTR_W+1)'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - (PTR_W+1)'(1);
        end
    end

endmodule

`default_nettype wire

// File: design/ttbd_back.sv
// ============================================================================
// ttbd_back
// Takes classified words from the queue and, while the output is not stalled,
// emits one RGBA8 texel per cycle into an output register, with its image coordinates.
// ============================================================================
`default_nettype none

module ttbd_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_not_empty,
    input  wire ttbd_pkg::work_entry_t        q_head,
    output logic                              q_pop,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [7:0]                        red,
    output logic [7:0]                        green,
    output logic [7:0]                        blue,
    output logic [7:0]                        alpha,
    output logic [ttbd_pkg::COORD_W-1:0]      pixel_x,
    output logic [ttbd_pkg::COORD_W-1:0]      pixel_y,
    output logic                              last_of_item,
    output logic                              last_of_image
);
    import ttbd_pkg::*;

    // Divide a value below 768 by three: multiply by 683 / 2048
    function automatic logic [7:0] div3(input logic [9:0] v);
        logic [19:0] p;
        p = {10'd0, v} * 20'd683;
        return p[18:11];
    endfunction

    work_entry_t        work_reg;
    logic               busy_reg;
    logic [3:0]         k_reg;

    logic               out_valid_reg;
    logic [7:0]         red_reg, green_reg, blue_reg, alpha_reg;
    logic [COORD_W-1:0] x_reg, y_reg;
    logic               li_reg, lim_reg;

    logic               adv, emit, done;
    logic [3:0]         last_k;

    logic [15:0]        t16, c0, c1;
    logic [7:0]         e0r, e0g, e0b, e1r, e1g, e1b;
    logic [7:0]         p2r, p2g, p2b, p3r, p3g, p3b, p3a;
    logic [7:0]         byte_sel;
    logic [1:0]         code, idx;
    logic [7:0]         tr, tg, tb, ta;
    logic [COORD_W-1:0] tx, ty;
    logic [2:0]         a3;

    // Handshake and sequencing
    assign last_k = (work_reg.fmt == FMT_CMP) ? 4'd15 : 4'd3;
    assign adv    = !out_valid_reg || !out_stall;
    assign emit   = busy_reg && adv;
    assign done   = emit && (k_reg == last_k);
    assign q_pop  = q_not_empty && (!busy_reg || done);

    // Build the CMP palette from the two endpoints
    always_comb
    begin
        c0  = work_reg.word[63:48];
        c1  = work_reg.word[47:32];
        e0r = {c0[15:11], c0[15:13]};
        e0g = {c0[10:5], c0[10:9]};
        e0b = {c0[4:0], c0[4:2]};
        e1r = {c1[15:11], c1[15:13]};
        e1g = {c1[10:5], c1[10:9]};
        e1b = {c1[4:0], c1[4:2]};
        p3r = div3({1'b0, e1r, 1'b0} + {2'b00, e0r} + 10'd1);
        p3g = div3({1'b0, e1g, 1'b0} + {2'b00, e0g} + 10'd1);
        p3b = div3({1'b0, e1b, 1'b0} + {2'b00, e0b} + 10'd1);
        if (c0 > c1)
        begin
            p2r = div3({1'b0, e0r, 1'b0} + {2'b00, e1r} + 10'd1);
            p2g = div3({1'b0, e0g, 1'b0} + {2'b00, e1g} + 10'd1);
            p2b = div3({1'b0, e0b, 1'b0} + {2'b00, e1b} + 10'd1);
            p3a = 8'hFF;
        end
        else
        begin
            p2r = 8'(({1'b0, e0r} + {1'b0, e1r} + 9'd1) >> 1);
            p2g = 8'(({1'b0, e0g} + {1'b0, e1g} + 9'd1) >> 1);
            p2b = 8'(({1'b0, e0b} + {1'b0, e1b} + 9'd1) >> 1);
            p3a = 8'h00;
        end
    end

    // Decode the current texel
    always_comb
    begin
        t16      = work_reg.word[(3 - int'(k_reg[1:0])) * 16 +: 16];
        byte_sel = work_reg.word[(3 - int'(k_reg[3:2])) * 8 +: 8];
        code     = byte_sel[(3 - int'(k_reg[1:0])) * 2 +: 2];
        idx      = {code[0], code[1]};
        a3       = t16[14:12];
        tx       = work_reg.x0 + {{(COORD_W-2){1'b0}}, k_reg[1:0]};
        if (work_reg.fmt == FMT_CMP)
        begin
            ty = work_reg.y0 + {{(COORD_W-2){1'b0}}, k_reg[3:2]};
            unique case (idx)
                2'd0:
                begin
                    tr = e0r; tg = e0g; tb = e0b; ta = 8'hFF;
                end
                2'd1:
                begin
                    tr = e1r; tg = e1g; tb = e1b; ta = 8'hFF;
                end
                2'd2:
                begin
                    tr = p2r; tg = p2g; tb = p2b; ta = 8'hFF;
                end
                default:
                begin
                    tr = p3r; tg = p3g; tb = p3b; ta = p3a;
                end
            endcase
        end
        else
        begin
            ty = work_reg.y0;
            if (t16[15])
            begin
                tr = {t16[14:10], t16[14:12]};
                tg = {t16[9:5], t16[9:7]};
                tb = {t16[4:0], t16[4:2]};
                ta = 8'hFF;
            end
            else
            begin
                tr = {t16[11:8], t16[11:8]};
                tg = {t16[7:4], t16[7:4]};
                tb = {t16[3:0], t16[3:0]};
                ta = {a3, a3, a3[2:1]};
            end
        end
    end

    // Load work and step through its texels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end
        else if (q_pop)
        begin
            busy_reg <= 1'b1;
            k_reg    <= '0;
        end
        else if (done)
            busy_reg <= 1'b0;
        else if (emit)
            k_reg <= k_reg + 4'd1;
    end

    // Hold the work word
    always_ff @(posedge clk)
    begin
        if (q_pop)
            work_reg <= q_head;
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= emit;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            red_reg   <= tr;
            green_reg <= tg;
            blue_reg  <= tb;
            alpha_reg <= ta;
            x_reg     <= tx;
            y_reg     <= ty;
            li_reg    <= (k_reg == last_k);
            lim_reg   <= (k_reg == last_k) && work_reg.wrap;
        end
    end

    assign out_valid     = out_valid_reg;
    assign red           = red_reg;
    assign green         = green_reg;
    assign blue          = blue_reg;
    assign alpha         = alpha_reg;
    assign pixel_x       = x_reg;
    assign pixel_y       = y_reg;
    assign last_of_item  = li_reg;
    assign last_of_image = lim_reg;

endmodule

`default_nettype wire

// File: design/tiled_texture_block_decoder_top.sv
// ============================================================================
// tiled_texture_block_decoder_top
// Decodes tiled RGB5A3 and CMP texture words into RGBA8 texels.
// ============================================================================
// Each accepted 64-bit word yields four texels for an RGB5A3 row and sixteen
// for a CMP sub-block; the texel back end emits one texel per clock while the
// output is not stalled. A two-entry queue sits between the input and the back
// end, so words are taken while texels of earlier words are still going out.
// With the queue and back end empty, a taken word passes the queue entry and
// the work register before its first texel enters the output register. That
// register holds a texel under stall and the back end waits with the next one.
// Write the configuration only while the block is idle; the tile position
// survives configuration writes and wraps once it reaches the new edge.
`default_nettype none

module tiled_texture_block_decoder_top #(
    parameter int MAX_DIM = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [ttbd_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [63:0]                   data_word,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [7:0]                         red,
    output logic [7:0]                         green,
    output logic [7:0]                         blue,
    output logic [7:0]                         alpha,
    output logic [ttbd_pkg::COORD_W-1:0]       pixel_x,
    output logic [ttbd_pkg::COORD_W-1:0]       pixel_y,
    output logic                               last_of_item,
    output logic                               last_of_image
);
    import ttbd_pkg::*;

    logic              format_reg;
    logic [CFG_W-1:0]  width_reg, height_reg;

    queue_write_t      q_wr;
    work_entry_t       q_head;
    logic              q_full, q_not_empty, q_pop;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= FMT_RGB5A3;
            width_reg  <= CFG_W'(1);
            height_reg <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FORMAT: format_reg <= cfg_data[0];
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    ttbd_front #(
        .MAX_DIM(MAX_DIM)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_word    (data_word),
        .fmt          (format_reg),
        .width_tiles  (width_reg),
        .height_tiles (height_reg),
        .q_full       (q_full),
        .q_wr         (q_wr)
    );

    ttbd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_wr      (q_wr),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .head      (q_head)
    );

    ttbd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .alpha         (alpha),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .last_of_item  (last_of_item),
        .last_of_image (last_of_image)
    );

endmodule

`default_nettype wire

// File: design/ttbd_checker.sv
// ============================================================================
// ttbd_checker
// Port-level checks on the texel output stream of the decoder top level.
// ============================================================================
`default_nettype none

`include "tiled_texture_block_decoder_top_macros.svh"

module ttbd_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  blue,
    input  wire logic [7:0]  alpha,
    input  wire logic [9:0]  pixel_x,
    input  wire logic [9:0]  pixel_y,
    input  wire logic        last_of_item,
    input  wire logic        last_of_image
);

    logic        out_hold;
    logic [53:0] out_word;

    // Gather the output transaction
    assign out_hold = out_valid && out_stall;
    assign out_word = {red, green, blue, alpha, pixel_x, pixel_y,
                       last_of_item, last_of_image};

    // Hold a stalled texel
    `TTBD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_hold, out_valid && $stable(out_word))

    // End of image only on the last texel of a word
    `TTBD_ASSERT_NOW(a_image_end, clk, rst_n, out_valid && last_of_image, last_of_item)

    // A word always ends on the right column of its four-texel-wide block
    `TTBD_ASSERT_NOW(a_item_col, clk, rst_n, out_valid && last_of_item, pixel_x[1:0] == 2'b11)

    // Texels of one word follow without gaps
    `TTBD_ASSERT_NEXT(a_no_gap, clk, rst_n, out_valid && !out_stall && !last_of_item, out_valid)

endmodule

bind tiled_texture_block_decoder_top ttbd_checker u_ttbd_checker (.*);

`default_nettype wire

// File: dv/tiled_texture_block_decoder_top_test.sv
// ============================================================================
// Tiled texture block decoder testbench
// Drives 64-bit texture words into the decoder under random input gaps and
// output stalls. An in-bench model decodes every accepted word into its
// RGBA8 texels and image coordinates. Each texel that leaves the block is
// compared field by field against the oldest predicted one.
// ============================================================================
module tiled_texture_block_decoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ttbd_pkg::*;

    localparam int MAX_DIM      = 1024;
    localparam int TILE_CAP     = (MAX_DIM / 4 < 256) ? MAX_DIM / 4 : 256;
    localparam int RANDOM_WORDS = 100;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE       = 4;
    localparam int TAIL_CYCLES  = 32;

    // One decoded texel as it appears on the output ports
    typedef struct packed {
        bit [7:0]         red;
        bit [7:0]         green;
        bit [7:0]         blue;
        bit [7:0]         alpha;
        bit [COORD_W-1:0] pixel_x;
        bit [COORD_W-1:0] pixel_y;
        bit               last_of_item;
        bit               last_of_image;
    } texel_t;

    // Tracks register settings and tile position, and holds decoded texels
    // that are still waiting to leave the block.
    class tile_texel_tracker;
        bit             fmt;
        bit [CFG_W-1:0] width_reg;
        bit [CFG_W-1:0] height_reg;
        int unsigned    col;
        int unsigned    row_base;
        bit [1:0]       sub_idx;
        bit [1:0]       row_idx;
        texel_t         pending_texels[$];
        int unsigned    mismatches;
        int unsigned    texels_checked;
        int unsigned    rgb_rows;
        int unsigned    cmp_blocks;
        int unsigned    image_wraps;

        function new();
            fmt            = FMT_RGB5A3;
            width_reg      = 1;
            height_reg     = 1;
            col            = 0;
            row_base       = 0;
            sub_idx        = 0;
            row_idx        = 0;
            mismatches     = 0;
            texels_checked = 0;
            rgb_rows       = 0;
            cmp_blocks     = 0;
            image_wraps    = 0;
        endfunction

        task log_mismatch(string msg);
            mismatches++;
            $display("MISMATCH: %s", msg);
        endtask

        function void write_reg(cfg_index_t idx, bit [CFG_W-1:0] value);
            case (idx)
                REG_FORMAT: fmt = value[0];
                REG_WIDTH:  width_reg = value;
                REG_HEIGHT: height_reg = value;
                default:    ;
            endcase
        endfunction

        // Zero counts as one tile; oversize values saturate at the cap
        function int unsigned tile_count(bit [CFG_W-1:0] v);
            if (v == 0)
                return 1;
            if (v > TILE_CAP)
                return TILE_CAP;
            return v;
        endfunction

        // Step right; at the edge drop down; report a return to the top left
        function bit advance_tile(int unsigned step, int unsigned drop);
            col += step;
            if (col >= tile_count(width_reg))
            begin
                col = 0;
                row_base += drop;
                if (row_base >= 4 * tile_count(height_reg))
                begin
                    row_base = 0;
                    image_wraps++;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function bit [7:0] expand5(bit [4:0] v);
            return {v, v[4:2]};
        endfunction

        function bit [7:0] expand6(bit [5:0] v);
            return {v, v[5:4]};
        endfunction

        function void push_texel(bit [7:0] r, bit [7:0] g, bit [7:0] b, bit [7:0] a,
                                 int unsigned x, int unsigned y, bit li, bit lim);
            texel_t t;
            t.red           = r;
            t.green         = g;
            t.blue          = b;
            t.alpha         = a;
            t.pixel_x       = x[COORD_W-1:0];
            t.pixel_y       = y[COORD_W-1:0];
            t.last_of_item  = li;
            t.last_of_image = lim;
            pending_texels.push_back(t);
        endfunction

        // One RGB5A3 word: four texels forming one row of a tile
        function void decode_rgb_row(bit [63:0] w);
            int unsigned y;
            int unsigned x0;
            bit          wrap;
            bit [15:0]   t;
            bit [2:0]    a3;
            bit [7:0]    r, g, b, a;
            y    = row_base + row_idx;
            x0   = col * 4;
            wrap = 1'b0;
            if (row_idx == 2'd3)
            begin
                row_idx = 0;
                wrap    = advance_tile(1, 4);
            end
            else
                row_idx++;
            for (int i = 0; i < 4; i++)
            begin
                t = w[63 - 16 * i -: 16];
                if (t[15])
                begin
                    r = expand5(t[14:10]);
                    g = expand5(t[9:5]);
                    b = expand5(t[4:0]);
                    a = 8'hff;
                end
                else
                begin
                    a3 = t[14:12];
                    a  = {a3, a3, a3[2:1]};
                    r  = {2{t[11:8]}};
                    g  = {2{t[7:4]}};
                    b  = {2{t[3:0]}};
                end
                push_texel(r, g, b, a, x0 + i, y, i == 3, i == 3 && wrap);
            end
            rgb_rows++;
        endfunction

        // One CMP word: a 4x4 sub-block with two RGB565 endpoints
        function void decode_cmp_block(bit [63:0] w);
            bit [1:0]    s;
            int unsigned x0;
            int unsigned y0;
            bit [15:0]   c0, c1;
            int unsigned pr[4], pg[4], pb[4], pa[4];
            bit          wrap;
            bit [7:0]    code_row;
            bit [1:0]    code;
            bit [1:0]    idx;
            s    = sub_idx;
            x0   = (col + s[0]) * 4;
            y0   = row_base + 4 * s[1];
            c0   = w[63:48];
            c1   = w[47:32];
            wrap = 1'b0;
            if (s == 2'd3)
            begin
                sub_idx = 0;
                wrap    = advance_tile(2, 8);
            end
            else
                sub_idx = s + 2'd1;

            // Build the four-entry palette
            pr[0] = 32'(expand5(c0[15:11]));
            pg[0] = 32'(expand6(c0[10:5]));
            pb[0] = 32'(expand5(c0[4:0]));
            pa[0] = 255;
            pr[1] = 32'(expand5(c1[15:11]));
            pg[1] = 32'(expand6(c1[10:5]));
            pb[1] = 32'(expand5(c1[4:0]));
            pa[1] = 255;
            pr[3] = (2 * pr[1] + pr[0] + 1) / 3;
            pg[3] = (2 * pg[1] + pg[0] + 1) / 3;
            pb[3] = (2 * pb[1] + pb[0] + 1) / 3;
            pa[2] = 255;
            if (c0 > c1)
            begin
                pr[2] = (2 * pr[0] + pr[1] + 1) / 3;
                pg[2] = (2 * pg[0] + pg[1] + 1) / 3;
                pb[2] = (2 * pb[0] + pb[1] + 1) / 3;
                pa[3] = 255;
            end
            else
            begin
                pr[2] = (pr[0] + pr[1] + 1) / 2;
                pg[2] = (pg[0] + pg[1] + 1) / 2;
                pb[2] = (pb[0] + pb[1] + 1) / 2;
                pa[3] = 0;
            end

            // Emit row by row; swap the two index bits before lookup
            for (int ty = 0; ty < 4; ty++)
            begin
                code_row = w[31 - 8 * ty -: 8];
                for (int tx = 0; tx < 4; tx++)
                begin
                    code = code_row[7 - 2 * tx -: 2];
                    idx  = {code[0], code[1]};
                    push_texel(8'(pr[idx]), 8'(pg[idx]), 8'(pb[idx]), 8'(pa[idx]),
                               x0 + tx, y0 + ty,
                               ty == 3 && tx == 3, ty == 3 && tx == 3 && wrap);
                end
            end
            cmp_blocks++;
        endfunction

        // Note an accepted input transaction
        function void decode_word(bit [63:0] w);
            if (fmt == FMT_CMP)
                decode_cmp_block(w);
            else
                decode_rgb_row(w);
        endfunction

        task check_field(string name, int unsigned seen_v, int unsigned want_v,
                         texel_t want);
            if (seen_v != want_v)
                log_mismatch($sformatf("%s of texel (%0d,%0d): got 0x%0h, expected 0x%0h",
                                       name, want.pixel_x, want.pixel_y, seen_v, want_v));
        endtask

        // Check an accepted output transaction against the oldest texel
        task compare_texel(texel_t seen);
            texel_t want;
            if (pending_texels.size() == 0)
            begin
                log_mismatch($sformatf("texel at (%0d,%0d) arrived with none pending",
                                       seen.pixel_x, seen.pixel_y));
                return;
            end
            want = pending_texels.pop_front();
            texels_checked++;
            check_field("red", 32'(seen.red), 32'(want.red), want);
            check_field("green", 32'(seen.green), 32'(want.green), want);
            check_field("blue", 32'(seen.blue), 32'(want.blue), want);
            check_field("alpha", 32'(seen.alpha), 32'(want.alpha), want);
            check_field("pixel_x", 32'(seen.pixel_x), 32'(want.pixel_x), want);
            check_field("pixel_y", 32'(seen.pixel_y), 32'(want.pixel_y), want);
            check_field("last_of_item", 32'(seen.last_of_item),
                        32'(want.last_of_item), want);
            check_field("last_of_image", 32'(seen.last_of_image),
                        32'(want.last_of_image), want);
        endtask
    endclass

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [1:0]           cfg_index = REG_FORMAT;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [63:0]          data_word = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic [7:0]           alpha;
    logic [COORD_W-1:0]   pixel_x;
    logic [COORD_W-1:0]   pixel_y;
    logic                 last_of_item;
    logic                 last_of_image;

    tile_texel_tracker    tracker;
    bit                   stalls_on = 1'b1;
    bit                   gaps_on   = 1'b1;
    int unsigned          stall_left = 0;
    int unsigned          quiet_cycles = 0;
    int unsigned          configs = 0;
    int unsigned          random_words = 0;

    bit [63:0] rgb_patterns [4] = '{
        64'h0000_FFFF_8000_7FFF,
        64'h7000_0FFF_8421_5A5A,
        64'hFC1F_83E0_F000_1234,
        64'hAAAA_5555_CCCC_3333
    };
    bit [63:0] cmp_patterns [8] = '{
        64'hFFFF_0000_E4E4_E4E4,
        64'h1234_1234_1B1B_1B1B,
        64'h0000_FFFF_E4E4_E4E4,
        64'hF800_07E0_FF00_55AA,
        64'h0000_0000_0000_0000,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'h07E0_001F_AAAA_5555,
        64'h001F_F800_0F0F_F0F0
    };

    tiled_texture_block_decoder_top #(
        .MAX_DIM(MAX_DIM)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_word(data_word),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .red(red),
        .green(green),
        .blue(blue),
        .alpha(alpha),
        .pixel_x(pixel_x),
        .pixel_y(pixel_y),
        .last_of_item(last_of_item),
        .last_of_image(last_of_image)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Idle lengths: mostly short, now and then long
    function automatic int unsigned idle_length();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            return $urandom_range(1, 3);
        if (pick < 9)
            return $urandom_range(4, 8);
        return $urandom_range(20, 40);
    endfunction

    function automatic int unsigned sender_gap();
        if (!gaps_on || $urandom_range(0, 2) != 0)
            return 0;
        return idle_length();
    endfunction

    // Favor small images so position wraps often, with the extremes mixed in
    function automatic bit [CFG_W-1:0] pick_tiles();
        case ($urandom_range(0, 7))
            0:       return CFG_W'(0);
            1:       return CFG_W'(1);
            2:       return CFG_W'(2);
            3:       return CFG_W'(256);
            4:       return CFG_W'(511);
            5:       return CFG_W'($urandom_range(257, 510));
            default: return CFG_W'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic bit [63:0] random_texture_word();
        bit [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0:       w[47:32] = w[63:48];
            1:       w[47:32] = w[63:48] + 16'($urandom_range(0, 2)) - 16'd1;
            default: ;
        endcase
        return w;
    endfunction

    // Hold the output back at random; stalls_on clear leaves it free-running
    always @(negedge clk)
    begin
        if (stall_left == 0 && stalls_on && $urandom_range(0, 3) == 0)
            stall_left = idle_length();
        out_stall <= (stall_left != 0);
        if (stall_left != 0)
            stall_left--;
    end

    // Sample both channels at the rising edge
    always @(posedge clk)
    begin : watch_ports
        texel_t seen;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                tracker.decode_word(data_word);
            if (out_valid && !out_stall)
            begin
                seen.red           = red;
                seen.green         = green;
                seen.blue          = blue;
                seen.alpha         = alpha;
                seen.pixel_x       = pixel_x;
                seen.pixel_y       = pixel_y;
                seen.last_of_item  = last_of_item;
                seen.last_of_image = last_of_image;
                tracker.compare_texel(seen);
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one word, starting and ending at a falling edge
    task automatic offer_word(bit [63:0] w, int unsigned gap);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_word <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid and wait until every predicted texel has left the block
    task automatic drain_texels();
        in_valid <= 1'b0;
        @(negedge clk);
        while (tracker.pending_texels.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, bit [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        tracker.write_reg(idx, value);
        @(negedge clk);
    endtask

    task automatic set_config(bit fmt, bit [CFG_W-1:0] w_tiles, bit [CFG_W-1:0] h_tiles);
        drain_texels();
        write_reg(REG_FORMAT, CFG_W'(fmt));
        write_reg(REG_WIDTH, w_tiles);
        write_reg(REG_HEIGHT, h_tiles);
        cfg_we <= 1'b0;
        configs++;
    endtask

    initial
    begin
        int unsigned n;
        tracker = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset registers: RGB5A3 on a single tile, so every fourth row wraps
        foreach (rgb_patterns[i])
            offer_word(rgb_patterns[i], 0);

        // CMP with zero size: both dimensions count as one tile
        set_config(FMT_CMP, 0, 0);
        foreach (cmp_patterns[i])
            offer_word(cmp_patterns[i], sender_gap());

        // Oversize registers saturate at the tile cap
        set_config(FMT_RGB5A3, 511, 257);
        foreach (rgb_patterns[i])
            offer_word(~rgb_patterns[i], sender_gap());

        // Odd width in CMP: the half chunk past the edge still comes out
        set_config(FMT_CMP, 3, 1);
        foreach (cmp_patterns[i])
            offer_word(cmp_patterns[i], sender_gap());

        // Random phases; the position carries over each register change
        while (random_words < RANDOM_WORDS)
        begin
            stalls_on = ($urandom_range(0, 4) != 0);
            gaps_on   = ($urandom_range(0, 4) != 0);
            set_config(1'($urandom_range(0, 1)), pick_tiles(), pick_tiles());
            n = $urandom_range(4, 24);
            repeat (n)
            begin
                offer_word(random_texture_word(), sender_gap());
                random_words++;
            end
        end

        drain_texels();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (tracker.pending_texels.size() != 0)
            tracker.log_mismatch($sformatf("%0d texels never arrived",
                                           tracker.pending_texels.size()));

        $display("Decoded %0d RGB5A3 rows and %0d CMP sub-blocks, %0d texels checked",
                 tracker.rgb_rows, tracker.cmp_blocks, tracker.texels_checked);
        $display("over %0d register settings with %0d image wraps",
                 configs, tracker.image_wraps);
        if (tracker.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
